### rtl/utcm_pkg.sv
// Shared types and constants for the carrier-modulated serial transmitter.
`default_nettype none

package utcm_pkg;

    localparam int CNT_W  = 16;
    localparam int SLOT_W = 4;

    localparam logic [SLOT_W-1:0] START_SLOT = 4'd0;
    localparam logic [SLOT_W-1:0] FIRST_DATA = 4'd1;
    localparam logic [SLOT_W-1:0] LAST_DATA  = 4'd8;
    localparam logic [SLOT_W-1:0] STOP_SLOT  = 4'd9;
    localparam logic [SLOT_W-1:0] DONE_SLOT  = 4'd10;

    localparam logic [CNT_W-1:0] BIT_PERIOD_RST     = 16'd6656;
    localparam logic [CNT_W-1:0] CARRIER_PERIOD_RST = 16'd16;
    localparam logic [CNT_W-1:0] CARRIER_HIGH_RST   = 16'd7;

    typedef enum logic [1:0] {
        REG_BIT_PERIOD     = 2'd0,
        REG_CARRIER_PERIOD = 2'd1,
        REG_CARRIER_HIGH   = 2'd2
    } reg_index_t;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    typedef struct packed {
        logic              pad;
        logic [SLOT_W-1:0] bit_position;
        logic              busy_res;
        logic              modulated_out;
        logic              line_level;
    } result_t;

endpackage

`default_nettype wire

### rtl/utcm_core.sv
// Bit timer, carrier counter, frame sequencer and result formation.
`default_nettype none

module utcm_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_accept,
    input  wire logic                        kind,
    input  wire logic [7:0]                  byte_value,
    input  wire logic                        cfg_write,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [utcm_pkg::CNT_W-1:0]  cfg_data,
    output utcm_pkg::result_t                result
);

    localparam int W = utcm_pkg::CNT_W;

    logic [W-1:0] bit_period_reg;
    logic [W-1:0] carrier_period_reg;
    logic [W-1:0] carrier_high_reg;

    logic [W-1:0] baud_count_reg, baud_count_next;
    logic [W-1:0] carrier_count_reg, carrier_count_next;
    logic [utcm_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0]   data_byte_reg, data_byte_next;
    logic         busy_reg, busy_next;
    logic         line_reg, line_next;
    logic         space_reg, space_next;
    logic         ticking_reg, ticking_next;

    logic [W:0]   carrier_inc;
    logic [W:0]   baud_inc;
    logic [W-1:0] carrier_step;
    logic         baud_wrap;
    logic [utcm_pkg::SLOT_W-1:0] slot_m1;
    logic [utcm_pkg::SLOT_W-1:0] slot_inc;

    assign carrier_inc  = {1'b0, carrier_count_reg} + {{W{1'b0}}, 1'b1};
    assign baud_inc     = {1'b0, baud_count_reg} + {{W{1'b0}}, 1'b1};
    assign carrier_step = (carrier_inc >= {1'b0, carrier_period_reg}) ? '0 : carrier_inc[W-1:0];
    assign baud_wrap    = baud_inc >= {1'b0, bit_period_reg};
    assign slot_m1      = slot_reg - utcm_pkg::FIRST_DATA;
    assign slot_inc     = slot_reg + utcm_pkg::FIRST_DATA;

    always_comb
    begin
        baud_count_next    = baud_count_reg;
        carrier_count_next = carrier_count_reg;
        slot_next          = slot_reg;
        data_byte_next     = data_byte_reg;
        busy_next          = busy_reg;
        line_next          = line_reg;
        space_next         = space_reg;
        ticking_next       = ticking_reg;
        if (item_accept)
        begin
            if (kind == utcm_pkg::KIND_START)
            begin
                data_byte_next  = byte_value;
                slot_next       = utcm_pkg::START_SLOT;
                busy_next       = 1'b1;
                baud_count_next = '0;
                ticking_next    = 1'b1;
            end
            else
            begin
                carrier_count_next = carrier_step;
                if (ticking_reg)
                begin
                    if (baud_wrap)
                    begin
                        baud_count_next = '0;
                        case (slot_reg) inside
                            utcm_pkg::START_SLOT:
                            begin
                                line_next  = 1'b0;
                                space_next = 1'b1;
                                slot_next  = slot_inc;
                            end
                            [utcm_pkg::FIRST_DATA:utcm_pkg::LAST_DATA]:
                            begin
                                line_next  = data_byte_reg[slot_m1[2:0]];
                                space_next = ~data_byte_reg[slot_m1[2:0]];
                                slot_next  = slot_inc;
                            end
                            utcm_pkg::STOP_SLOT:
                            begin
                                line_next    = 1'b1;
                                space_next   = 1'b0;
                                busy_next    = 1'b0;
                                ticking_next = 1'b0;
                                slot_next    = slot_inc;
                            end
                            default:
                            begin
                                ticking_next = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        baud_count_next = baud_inc[W-1:0];
                    end
                end
            end
        end
    end

    always_comb
    begin
        result               = '0;
        result.line_level    = line_next;
        result.modulated_out = space_next ? (carrier_count_next < carrier_high_reg) : 1'b1;
        result.busy_res      = busy_next;
        result.bit_position  = slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg     <= utcm_pkg::BIT_PERIOD_RST;
            carrier_period_reg <= utcm_pkg::CARRIER_PERIOD_RST;
            carrier_high_reg   <= utcm_pkg::CARRIER_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                utcm_pkg::REG_BIT_PERIOD:     bit_period_reg     <= cfg_data;
                utcm_pkg::REG_CARRIER_PERIOD: carrier_period_reg <= cfg_data;
                utcm_pkg::REG_CARRIER_HIGH:   carrier_high_reg   <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baud_count_reg    <= '0;
            carrier_count_reg <= '0;
            slot_reg          <= utcm_pkg::DONE_SLOT;
            data_byte_reg     <= '0;
            busy_reg          <= 1'b0;
            line_reg          <= 1'b1;
            space_reg         <= 1'b0;
            ticking_reg       <= 1'b0;
        end
        else
        begin
            baud_count_reg    <= baud_count_next;
            carrier_count_reg <= carrier_count_next;
            slot_reg          <= slot_next;
            data_byte_reg     <= data_byte_next;
            busy_reg          <= busy_next;
            line_reg          <= line_next;
            space_reg         <= space_next;
            ticking_reg       <= ticking_next;
        end
    end

endmodule

`default_nettype wire

### rtl/utcm_outbuf.sv
// Two-entry result register with skid stage.
`default_nettype none

module utcm_outbuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  utcm_pkg::result_t      in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output utcm_pkg::result_t      out_data
);

    utcm_pkg::result_t out_reg;
    utcm_pkg::result_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic push;
    logic pop;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign push      = in_valid & in_ready;
    assign pop       = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg | push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        else if (push)
        begin
            skid_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

### rtl/uart_tx_carrier_modulated.sv
// Top level of the 8N1 serial transmitter with on-off-keyed carrier output.
`default_nettype none

// Each input item is either one clock tick or a start request carrying a byte, and each
// produces exactly one result item giving the line level, the carrier-gated level, busy and
// the next bit slot as they stand after the item. The block takes one item per cycle while
// s_tready is high; its result is registered in the output buffer. A two-entry result buffer
// lets an item be accepted while an earlier result is still waiting, and s_tready drops only
// when both entries are full. Configuration writes are always accepted (cfg_ready is high).

module uart_tx_carrier_modulated (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] line_level, [1] modulated_out, [2] busy_res,
                                        // [6:3] bit_position, [7] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    utcm_pkg::result_t core_result;
    utcm_pkg::result_t buf_result;
    logic item_accept;

    assign cfg_ready   = 1'b1;
    assign item_accept = s_tvalid & s_tready;
    assign m_tdata     = buf_result;

    utcm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .kind        (s_tuser[0]),
        .byte_value  (s_tdata),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result      (core_result)
    );

    utcm_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_result)
    );

`ifndef SYNTHESIS
    a_full_implies_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:3] <= utcm_pkg::DONE_SLOT)
        else $error("bit position out of range");

    a_busy_before_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[6:3] <= utcm_pkg::STOP_SLOT)
        else $error("busy after stop bit");

    a_idle_is_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
        else $error("line not at mark while idle");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_uart_tx_carrier_modulated.sv
// Testbench for the carrier-modulated 8N1 transmitter: stimulus, line prediction, result check.
`timescale 1ns / 100ps

module tb_uart_tx_carrier_modulated;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = utcm_pkg::KIND_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = utcm_pkg::REG_BIT_PERIOD;
    logic [15:0] cfg_data = 16'h0000;

    logic [15:0] bit_per, car_per, car_high;
    logic [15:0] baud_cnt, car_cnt;
    logic [3:0]  slot;
    logic [7:0]  frame_byte;
    logic        busy, line, space, timer_on;

    utcm_pkg::result_t pending_levels[$];
    int          items_fed = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          src_steady = 1'b0;
    bit          snk_steady = 1'b0;

    uart_tx_carrier_modulated i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] byte_value
        .s_tuser   (s_tuser),   // [0] kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] line_level, [1] modulated_out, [2] busy_res,
                                // [6:3] bit_position, [7] zero
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL uart_tx_carrier_modulated");
            $finish;
        end
    end

    function automatic utcm_pkg::result_t advance_line(utcm_pkg::kind_t k, logic [7:0] b);
        utcm_pkg::result_t r;
        if (k == utcm_pkg::KIND_START)
        begin
            frame_byte = b;
            slot = utcm_pkg::START_SLOT;
            busy = 1'b1;
            baud_cnt = '0;
            timer_on = 1'b1;
        end
        else
        begin
            if ({1'b0, car_cnt} + 17'd1 >= {1'b0, car_per})
                car_cnt = '0;
            else
                car_cnt = car_cnt + 16'd1;
            if (timer_on)
            begin
                if ({1'b0, baud_cnt} + 17'd1 >= {1'b0, bit_per})
                begin
                    baud_cnt = '0;
                    if (slot <= utcm_pkg::STOP_SLOT)
                    begin
                        if (slot == utcm_pkg::START_SLOT)
                            line = 1'b0;
                        else if (slot <= utcm_pkg::LAST_DATA)
                            line = frame_byte[slot - utcm_pkg::FIRST_DATA];
                        else
                        begin
                            line = 1'b1;
                            busy = 1'b0;
                            timer_on = 1'b0;
                        end
                        space = ~line;
                        slot = slot + 4'd1;
                    end
                    else
                        timer_on = 1'b0;
                end
                else
                    baud_cnt = baud_cnt + 16'd1;
            end
        end
        r.pad = 1'b0;
        r.line_level = line;
        r.modulated_out = space ? (car_cnt < car_high) : 1'b1;
        r.busy_res = busy;
        r.bit_position = slot;
        return r;
    endfunction

    task automatic send_item(utcm_pkg::kind_t k, logic [7:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_steady = ~src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= b;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        pending_levels.push_back(advance_line(k, b));
        items_fed++;
    endtask

    task automatic await_results();
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        case (idx)
            utcm_pkg::REG_BIT_PERIOD:     bit_per = val;
            utcm_pkg::REG_CARRIER_PERIOD: car_per = val;
            utcm_pkg::REG_CARRIER_HIGH:   car_high = val;
            default: ;
        endcase
    endtask

    task automatic set_config(int bp, int cp, int ch, bit poke_unused);
        await_results();
        write_reg(utcm_pkg::REG_BIT_PERIOD, bp[15:0]);
        write_reg(utcm_pkg::REG_CARRIER_PERIOD, cp[15:0]);
        write_reg(utcm_pkg::REG_CARRIER_HIGH, ch[15:0]);
        if (poke_unused)
            write_reg(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic check_result(logic [7:0] data);
        utcm_pkg::result_t got, want;
        got = utcm_pkg::result_t'(data);
        if (pending_levels.size() == 0)
        begin
            $error("result with nothing pending: %h", data);
            mismatches++;
        end
        else
        begin
            want = pending_levels.pop_front();
            if (got.line_level !== want.line_level)
            begin
                $error("line_level expected %0d got %0d", want.line_level, got.line_level);
                mismatches++;
            end
            if (got.modulated_out !== want.modulated_out)
            begin
                $error("modulated_out expected %0d got %0d",
                       want.modulated_out, got.modulated_out);
                mismatches++;
            end
            if (got.busy_res !== want.busy_res)
            begin
                $error("busy_res expected %0d got %0d", want.busy_res, got.busy_res);
                mismatches++;
            end
            if (got.bit_position !== want.bit_position)
            begin
                $error("bit_position expected %0d got %0d",
                       want.bit_position, got.bit_position);
                mismatches++;
            end
            if (got.pad !== want.pad)
            begin
                $error("pad expected %0d got %0d", want.pad, got.pad);
                mismatches++;
            end
        end
    endtask

    initial
    begin : result_sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                snk_steady = ~snk_steady;
            gap = snk_steady ? 0 : $urandom_range(0, 10);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
            while (!m_tvalid) @(negedge clk);
            check_result(m_tdata);
            @(posedge clk);
        end
    end

    task automatic test_reset_defaults();
        send_item(utcm_pkg::KIND_TICK, 8'h00);
        send_item(utcm_pkg::KIND_TICK, 8'hFF);
        send_item(utcm_pkg::KIND_START, 8'h5A);
        send_item(utcm_pkg::KIND_TICK, 8'h00);
    endtask

    task automatic test_fast_frame();
        set_config(0, 1, 0, 1'b0);
        send_item(utcm_pkg::KIND_START, 8'hFF);
        repeat (11) send_item(utcm_pkg::KIND_TICK, 8'h00);
    endtask

    task automatic test_restart();
        set_config(1, 0, 65535, 1'b1);
        send_item(utcm_pkg::KIND_START, 8'h00);
        repeat (2) send_item(utcm_pkg::KIND_TICK, 8'h00);
        send_item(utcm_pkg::KIND_START, 8'h81);
        repeat (2) send_item(utcm_pkg::KIND_TICK, 8'h00);
    endtask

    task automatic test_extreme_registers();
        set_config(65535, 65535, 65535, 1'b1);
        send_item(utcm_pkg::KIND_START, 8'hC3);
        repeat (2) send_item(utcm_pkg::KIND_TICK, 8'h00);
    endtask

    task automatic test_period_shrink();
        set_config(3, 2, 1, 1'b0);
        repeat (3) send_item(utcm_pkg::KIND_TICK, 8'h00);
    endtask

    task automatic test_random_traffic();
        int goal, phase_end, bp, cp, ch, ticks, bp_eff;
        goal = items_fed + RANDOM_ITEMS;
        while (items_fed < goal)
        begin
            case ($urandom_range(0, 5))
                0:       bp = $urandom_range(0, 2);
                default: bp = $urandom_range(3, 7);
            endcase
            case ($urandom_range(0, 6))
                0:       cp = $urandom_range(0, 1);
                1:       cp = 65535;
                default: cp = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 6))
                0:       ch = 0;
                1:       ch = 65535;
                default: ch = $urandom_range(0, cp + 1);
            endcase
            set_config(bp, cp, ch, $urandom_range(0, 3) == 0);
            phase_end = items_fed + $urandom_range(80, 140);
            while (items_fed < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(utcm_pkg::kind_t'($urandom_range(0, 1)), 8'($urandom));
                else
                begin
                    send_item(utcm_pkg::KIND_START, 8'($urandom));
                    bp_eff = (bit_per < 2) ? 1 : bit_per;
                    ticks = 11 * bp_eff + $urandom_range(0, 4);
                    if ($urandom_range(0, 5) == 0)
                        ticks = $urandom_range(0, ticks);
                    repeat (ticks) send_item(utcm_pkg::KIND_TICK, 8'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        bit_per = utcm_pkg::BIT_PERIOD_RST;
        car_per = utcm_pkg::CARRIER_PERIOD_RST;
        car_high = utcm_pkg::CARRIER_HIGH_RST;
        baud_cnt = '0;
        car_cnt = '0;
        slot = utcm_pkg::DONE_SLOT;
        frame_byte = '0;
        busy = 1'b0;
        line = 1'b1;
        space = 1'b0;
        timer_on = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_fast_frame();
        test_restart();
        test_extreme_registers();
        test_period_shrink();
        test_random_traffic();
        await_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS uart_tx_carrier_modulated");
        else
            $display("FAIL uart_tx_carrier_modulated");
        $finish;
    end

endmodule
